// ===== rtl/lsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line span rasterizer package
// Shared widths, item codes, register map and the divider handshake types.
// ----------------------------------------------------------------------------
package lsr_pkg;

	localparam int COORD_BITS = 10;
	// Current x and the error term need two bits beyond a coordinate, with sign.
	localparam int XW = COORD_BITS + 2;
	localparam int EW = COORD_BITS + 2;
	// The dividend is the positive error term, so its sign bit is dropped.
	localparam int QW = EW - 1;
	localparam int DIV_CNT_W = $clog2(QW + 1);

	localparam int COLOR_W = 15;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 15'd26425;

	localparam int IN_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_W = ((3 * COORD_BITS + COLOR_W + 7) / 8) * 8;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_LINE_COLOR = 1'b0;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_ADVANCE = 1'b1;

	localparam logic [1:0] KIND_HORIZ = 2'd0;
	localparam logic [1:0] KIND_VERT = 2'd1;
	localparam logic [1:0] KIND_DIAG = 2'd2;

	typedef struct packed {
		logic                  start;
		logic [QW-1:0]         dividend;
		logic [COORD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [QW-1:0]         quotient;
		logic [COORD_BITS-1:0] remainder;
	} div_rsp_t;

endpackage

// ===== rtl/line_span_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line span rasterizer
// Orders two endpoints on load and emits one horizontal span per advance item while a line is loaded.
// ----------------------------------------------------------------------------
// A load item gives no result.
// An advance item passes through the row state into the output register, which
// waits while a span is unaccepted; a long diagonal run first waits for the
// bit-serial divider, one quotient bit per cycle. One item is worked on at a time.
// Reset is asynchronous, active low: idle, no line loaded, color 26425.
module line_span_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lsr_pkg::IN_W-1:0]      s_tdata,  // x_a, y_a, x_b, y_b
	input  logic                          s_tuser,  // action
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lsr_pkg::OUT_W-1:0]     m_tdata,  // row, span_left, span_right, pixel_color
	output logic                          m_tuser,  // span_empty
	output logic                          m_tlast,  // last_span
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsr_pkg::PADDR_W-1:0]   paddr,
	input  logic [lsr_pkg::PDATA_W-1:0]   pwdata,
	output logic [lsr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int CB = lsr_pkg::COORD_BITS;
	localparam int XW = lsr_pkg::XW;
	localparam int EW = lsr_pkg::EW;
	localparam int QW = lsr_pkg::QW;
	localparam int W  = XW + 1;
	localparam int OW = lsr_pkg::OUT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROW  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	localparam logic signed [W-1:0] ONE_W = W'(1);
	localparam logic signed [XW-1:0] ONE_X = XW'(1);

	logic [1:0]                  state_q;
	logic                        busy_q;
	logic [1:0]                  kind_q;
	logic                        step_left_q;
	logic signed [XW-1:0]        cur_x_q;
	logic [CB-1:0]               cur_y_q;
	logic [CB-1:0]               end_x_q;
	logic [CB-1:0]               end_y_q;
	logic [CB-1:0]               dx_q;
	logic [CB-1:0]               dy_q;
	logic signed [EW-1:0]        err_q;

	logic                        m_tvalid_q;
	logic [OW-1:0]               m_tdata_q;
	logic                        m_tuser_q;
	logic                        m_tlast_q;

	logic [lsr_pkg::COLOR_W-1:0] line_color;
	lsr_pkg::div_req_t           div_req;
	lsr_pkg::div_rsp_t           div_rsp;

	lsr_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.line_color (line_color)
	);

	lsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- load: order the endpoints ----------------
	logic [CB-1:0]        xa, ya, xb, yb;
	logic                 swap;
	logic [CB-1:0]        xs, ys, xe, ye;
	logic                 ld_left;
	logic [CB-1:0]        ld_dx, ld_dy;
	logic [1:0]           ld_kind;
	logic signed [EW-1:0] ld_err;

	assign xa = s_tdata[CB-1:0];
	assign ya = s_tdata[2*CB-1:CB];
	assign xb = s_tdata[3*CB-1:2*CB];
	assign yb = s_tdata[4*CB-1:3*CB];

	always_comb begin
		swap    = (ya == yb) ? (xb < xa) : (yb < ya);
		xs      = swap ? xb : xa;
		ys      = swap ? yb : ya;
		xe      = swap ? xa : xb;
		ye      = swap ? ya : yb;
		ld_left = xe < xs;
		ld_dx   = ld_left ? xs - xe : xe - xs;
		ld_dy   = ye - ys;
		if (ys == ye) begin
			ld_kind = lsr_pkg::KIND_HORIZ;
		end else if (xs == xe) begin
			ld_kind = lsr_pkg::KIND_VERT;
		end else begin
			ld_kind = lsr_pkg::KIND_DIAG;
		end
		if (ld_dx > ld_dy) begin
			ld_err = $signed({2'b00, ld_dx >> 1});
		end else begin
			ld_err = -$signed({2'b00, ld_dy >> 1});
		end
	end

	// ---------------- row step ----------------
	logic signed [W-1:0]  x_w, ex_w, run_w;
	logic signed [EW-1:0] dx_e, dy_e, rem_e;
	logic signed [W-1:0]  lo_w, hi_w;
	logic                 last_w, empty_w, need_div, slot_free, emit;
	logic signed [XW-1:0] cur_x_n;
	logic [CB-1:0]        cur_y_n;
	logic signed [EW-1:0] err_n;

	assign x_w   = {cur_x_q[XW-1], cur_x_q};
	assign ex_w  = $signed({3'b000, end_x_q});
	assign run_w = $signed({2'b00, div_rsp.quotient});
	assign dx_e  = $signed({2'b00, dx_q});
	assign dy_e  = $signed({2'b00, dy_q});
	assign rem_e = $signed({2'b00, div_rsp.remainder});

	always_comb begin
		lo_w     = x_w;
		hi_w     = x_w;
		last_w   = 1'b0;
		need_div = 1'b0;
		cur_x_n  = cur_x_q;
		cur_y_n  = cur_y_q;
		err_n    = err_q;
		if (state_q == ST_DIV) begin
			// A long run: the quotient is the run length, the remainder less dy plus dx the new error.
			if (!step_left_q) begin
				hi_w    = x_w + run_w;
				cur_x_n = XW'(hi_w + ONE_W);
				if (hi_w > ex_w) begin
					hi_w = ex_w;
				end
			end else begin
				lo_w    = x_w - run_w;
				cur_x_n = XW'(lo_w - ONE_W);
				if (lo_w < ex_w) begin
					lo_w = ex_w;
				end
			end
			err_n   = rem_e - dy_e + dx_e;
			cur_y_n = cur_y_q + CB'(1);
		end else begin
			unique case (kind_q)
				lsr_pkg::KIND_HORIZ: begin
					hi_w   = ex_w;
					last_w = 1'b1;
				end
				lsr_pkg::KIND_VERT: begin
					if (cur_y_q >= end_y_q) begin
						last_w = 1'b1;
					end else begin
						cur_y_n = cur_y_q + CB'(1);
					end
				end
				lsr_pkg::KIND_DIAG: begin
					if (cur_y_q >= end_y_q) begin
						// The final row takes what is left of the line up to end x.
						last_w = 1'b1;
						if (!step_left_q) begin
							hi_w = ex_w;
						end else begin
							lo_w = ex_w;
						end
					end else if (x_w == ex_w) begin
						cur_y_n = cur_y_q + CB'(1);
					end else if (err_q < dy_e) begin
						cur_y_n = cur_y_q + CB'(1);
						if (err_q > -dx_e) begin
							cur_x_n = step_left_q ? cur_x_q - ONE_X : cur_x_q + ONE_X;
							err_n   = err_q + dx_e - dy_e;
						end else begin
							err_n = err_q + dx_e;
						end
					end else begin
						need_div = 1'b1;
					end
				end
				default: begin
					last_w = 1'b1;
				end
			endcase
		end
		empty_w = lo_w > hi_w;
		if (empty_w) begin
			lo_w = ex_w;
			hi_w = ex_w;
		end
	end

	assign slot_free = !m_tvalid_q || m_tready;
	assign emit      = ((state_q == ST_ROW) && slot_free && !need_div) ||
	                   ((state_q == ST_DIV) && div_rsp.done);
	assign s_tready  = (state_q == ST_IDLE);

	assign div_req.start    = (state_q == ST_ROW) && slot_free && need_div;
	assign div_req.dividend = err_q[QW-1:0];
	assign div_req.divisor  = dy_q;

	// ---------------- control and line state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			busy_q      <= 1'b0;
			kind_q      <= lsr_pkg::KIND_HORIZ;
			step_left_q <= 1'b0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			end_x_q     <= '0;
			end_y_q     <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			err_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == lsr_pkg::ACT_LOAD) begin
							busy_q      <= 1'b1;
							kind_q      <= ld_kind;
							step_left_q <= ld_left;
							cur_x_q     <= $signed({2'b00, xs});
							cur_y_q     <= ys;
							end_x_q     <= xe;
							end_y_q     <= ye;
							dx_q        <= ld_dx;
							dy_q        <= ld_dy;
							err_q       <= ld_err;
						end else if (busy_q) begin
							state_q <= ST_ROW;
						end
					end
				end
				ST_ROW: begin
					if (slot_free) begin
						state_q <= need_div ? ST_DIV : ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				cur_x_q <= cur_x_n;
				cur_y_q <= cur_y_n;
				err_q   <= err_n;
				if (last_w) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= OW'({line_color, hi_w[CB-1:0], lo_w[CB-1:0], cur_y_q});
			m_tuser_q <= empty_w;
			m_tlast_q <= last_w;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// ---------------- assertions ----------------
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (busy_q && (kind_q == lsr_pkg::KIND_DIAG)))
		else $error("divider running without a diagonal line loaded");

	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (kind_q == lsr_pkg::KIND_DIAG)) |-> ((err_q >= -dy_e) && (err_q <= dx_e + dy_e)))
		else $error("error term left its range");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> ((state_q == ST_DIV) && (div_rsp.remainder < dy_q)))
		else $error("divider result out of place or remainder not below divisor");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> (m_tdata_q[2*CB-1:CB] == m_tdata_q[3*CB-1:2*CB]))
		else $error("empty span with differing columns");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == lsr_pkg::ACT_ADVANCE) && !busy_q) |=> (state_q == ST_IDLE))
		else $error("advance while idle started a row");

endmodule

// ===== rtl/lsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line span rasterizer run divider
// Bit-serial restoring divider: one quotient bit per cycle, QW quotient bits per run.
// ----------------------------------------------------------------------------
module lsr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lsr_pkg::div_req_t req,
	output lsr_pkg::div_rsp_t rsp
);

	localparam int CB = lsr_pkg::COORD_BITS;
	localparam int QW = lsr_pkg::QW;
	localparam int CW = lsr_pkg::DIV_CNT_W;

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [CB-1:0] rem_q;
	logic [QW-1:0] num_q;
	logic [CB-1:0] div_q;

	logic [CB:0]   trial;
	logic [CB+1:0] diff;
	logic          fits;

	// The dividend shifts out at the top while quotient bits shift in below.
	assign trial = {rem_q, num_q[QW-1]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign fits  = ~diff[CB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.dividend;
			div_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[CB-1:0] : trial[CB-1:0];
			num_q <= {num_q[QW-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = num_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== rtl/lsr_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line span rasterizer register block
// APB-style port holding the line color register.
// ----------------------------------------------------------------------------
module lsr_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [lsr_pkg::PADDR_W-1:0]   paddr,
	input  logic [lsr_pkg::PDATA_W-1:0]   pwdata,
	output logic [lsr_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output logic [lsr_pkg::COLOR_W-1:0]   line_color
);

	localparam int PW = lsr_pkg::PDATA_W;
	localparam int CW = lsr_pkg::COLOR_W;

	logic [CW-1:0] color_q;
	logic          sel_color;

	// Registers sit on 4-byte steps, so the index is the address above bit 1.
	assign sel_color = (paddr[lsr_pkg::PADDR_W-1:2] == lsr_pkg::REG_LINE_COLOR);
	assign pready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= lsr_pkg::COLOR_RESET;
		end else if (psel && penable && pwrite && pready && sel_color) begin
			color_q <= pwdata[CW-1:0];
		end
	end

	assign prdata     = sel_color ? PW'(color_q) : '0;
	assign line_color = color_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line span rasterizer testbench
// Streams line loads and row advances into the block and checks every span.
// A small scoreboard follows the endpoint ordering and the run-sliced error
// stepping row by row. It compares each span with the oldest expected one.
// Both stream sides stall at random, and the edge color is changed between
// phases over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
	import lsr_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int ITEM_TARGET = 1600;
	localparam int PHASES = 6;
	localparam int SETTLE_CYCLES = 20;

	typedef logic [CB-1:0] coord_t;

	typedef struct packed {
		coord_t               row;
		coord_t               left;
		coord_t               right;
		logic                 empty;
		logic                 last;
		logic [COLOR_W-1:0]   color;
	} span_t;

	class span_board;
		span_t              spans_due[$];
		logic [COLOR_W-1:0] color;
		logic [1:0]         kind;
		bit                 active;
		bit                 to_left;
		int                 cur_x, cur_y, end_x, end_y, dx, dy, err;
		int                 errors;
		int                 spans_ok;

		function new();
			color = COLOR_RESET;
			kind = KIND_HORIZ;
			active = 0;
			to_left = 0;
			cur_x = 0;
			cur_y = 0;
			end_x = 0;
			end_y = 0;
			dx = 0;
			dy = 0;
			err = 0;
			errors = 0;
			spans_ok = 0;
		endfunction

		function void mismatch(string msg);
			errors++;
			if (errors <= 10) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
		endfunction

		function int pending();
			return spans_due.size();
		endfunction

		// Returns 1 when the item does something, 0 when the block ignores it.
		function bit take_item(logic act, coord_t xa, coord_t ya, coord_t xb, coord_t yb);
			int ax, ay, bx, by, t, row, lo, hi, run;
			bit last;
			span_t s;
			if (act == ACT_LOAD) begin
				ax = xa;
				ay = ya;
				bx = xb;
				by = yb;
				if ((ay == by) ? (bx < ax) : (by < ay)) begin
					t = ax; ax = bx; bx = t;
					t = ay; ay = by; by = t;
				end
				cur_x = ax;
				cur_y = ay;
				end_x = bx;
				end_y = by;
				to_left = bx < ax;
				dx = to_left ? ax - bx : bx - ax;
				dy = by - ay;
				if (ay == by) begin
					kind = KIND_HORIZ;
				end else if (ax == bx) begin
					kind = KIND_VERT;
				end else begin
					kind = KIND_DIAG;
				end
				err = (dx > dy) ? dx / 2 : -(dy / 2);
				active = 1;
				return 1;
			end
			if (!active) begin
				return 0;
			end
			row = cur_y;
			last = 0;
			if (kind == KIND_HORIZ) begin
				lo = cur_x;
				hi = end_x;
				last = 1;
			end else if (kind == KIND_VERT) begin
				lo = cur_x;
				hi = cur_x;
				if (cur_y >= end_y) begin
					last = 1;
				end else begin
					cur_y++;
				end
			end else if (cur_y >= end_y) begin
				// The final row takes whatever is left up to the end column.
				last = 1;
				lo = to_left ? end_x : cur_x;
				hi = to_left ? cur_x : end_x;
			end else begin
				if (cur_x == end_x) begin
					lo = cur_x;
					hi = cur_x;
				end else if (err < dy) begin
					lo = cur_x;
					hi = cur_x;
					if (err > -dx) begin
						cur_x = to_left ? cur_x - 1 : cur_x + 1;
						err += dx - dy;
					end else begin
						err += dx;
					end
				end else begin
					// A long run: its length is the error divided by dy.
					run = err / dy;
					err -= dy * (run + 1);
					if (!to_left) begin
						lo = cur_x;
						hi = cur_x + run;
						cur_x = hi + 1;
						if (hi > end_x) begin
							hi = end_x;
						end
					end else begin
						hi = cur_x;
						lo = cur_x - run;
						cur_x = lo - 1;
						if (lo < end_x) begin
							lo = end_x;
						end
					end
					err += dx;
				end
				cur_y++;
			end
			s.empty = lo > hi;
			if (s.empty) begin
				lo = end_x;
				hi = end_x;
			end
			if (last) begin
				active = 0;
			end
			s.row = coord_t'(row);
			s.left = coord_t'(lo);
			s.right = coord_t'(hi);
			s.last = last;
			s.color = color;
			spans_due.push_back(s);
			return 1;
		endfunction

		function void check_span(logic [OUT_W-1:0] d, logic empty, logic last);
			span_t got, want;
			got.row = d[CB-1:0];
			got.left = d[2*CB-1:CB];
			got.right = d[3*CB-1:2*CB];
			got.color = d[3*CB+COLOR_W-1:3*CB];
			got.empty = empty;
			got.last = last;
			if (spans_due.size() == 0) begin
				mismatch($sformatf("span with nothing expected: row %0d cols %0d..%0d",
					got.row, got.left, got.right));
				return;
			end
			want = spans_due.pop_front();
			if (got !== want) begin
				mismatch($sformatf({"expected row %0d cols %0d..%0d empty %0b last %0b ",
					"color %h, got row %0d cols %0d..%0d empty %0b last %0b color %h"},
					want.row, want.left, want.right, want.empty, want.last, want.color,
					got.row, got.left, got.right, got.empty, got.last, got.color));
			end else begin
				spans_ok++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata;   // x_a, y_a, x_b, y_b
	logic                s_tuser;   // action
	logic                m_tvalid;
	logic                m_tready;
	logic [OUT_W-1:0]    m_tdata;   // row, span_left, span_right, pixel_color
	logic                m_tuser;   // span_empty
	logic                m_tlast;   // last_span
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	span_board sb = new();

	bit quiet = 0;
	bit hold_req = 0;
	int items = 0;
	int loads = 0;
	int color_writes = 0;

	line_span_rasterizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Called and left at a falling edge.
	task automatic send_item(logic act, coord_t xa, coord_t ya, coord_t xb, coord_t yb);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {yb, xb, ya, xa};
		do @(posedge clk); while (!s_tready);
		if (sb.take_item(act, xa, ya, xb, yb)) begin
			items++;
		end
		if (act == ACT_LOAD) begin
			loads++;
		end
		@(negedge clk);
	endtask

	task automatic load_line(int xa, int ya, int xb, int yb);
		send_item(ACT_LOAD, coord_t'(xa), coord_t'(ya), coord_t'(xb), coord_t'(yb));
	endtask

	task automatic advance(int n);
		repeat (n) send_item(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	// Stops offering items and waits until every expected span has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_color(logic [COLOR_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * REG_LINE_COLOR);
		pwdata <= PDATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		sb.color = value;
		color_writes++;
		@(negedge clk);
		pwrite <= 1'b0;
		@(negedge clk);
		psel <= 1'b1;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDATA_W'(value)) begin
			sb.mismatch($sformatf("color reads back %h, written %h", prdata, value));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// One random line, mostly drawn to its last row, sometimes cut short by
	// the next load, now and then followed by an extra advance or noise.
	task automatic random_line();
		int xa, ya, xb, yb, dy, shape, rows, cut;
		shape = $urandom_range(0, 99);
		dy = ($urandom_range(0, 49) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 14);
		if (shape < 10) begin
			dy = 0;
		end
		xa = $urandom_range(0, 1023);
		ya = $urandom_range(0, 1023);
		if (shape < 20) begin
			xb = xa;
		end else if (shape < 55) begin
			xb = (xa + $urandom_range(0, 2 * dy + 2) - (dy + 1)) & 1023;
		end else begin
			xb = $urandom_range(0, 1023);
		end
		if (ya >= dy && ($urandom_range(0, 1) == 1 || ya + dy > 1023)) begin
			yb = ya - dy;
		end else begin
			yb = ya + dy;
		end
		load_line(xa, ya, xb, yb);
		rows = dy + 1;
		cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rows - 1) : rows;
		advance(cut);
		if ($urandom_range(0, 9) == 0) begin
			advance(1);
		end
		if ($urandom_range(0, 19) == 0) begin
			send_item(logic'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin : span_sink
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				stall = 400;
			end else begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_span(m_tdata, m_tuser, m_tlast);
		end
	end

	initial begin : stimulus
		int ph;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= ACT_LOAD;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed lines at the reset color.
		advance(1);                       // nothing loaded yet
		load_line(5, 7, 5, 7);            // single pixel
		advance(1);
		load_line(1023, 0, 0, 0);         // horizontal, given right to left
		advance(1);
		load_line(0, 1023, 1023, 1023);
		advance(1);
		load_line(9, 1023, 9, 1021);      // vertical, given bottom up
		advance(3);
		load_line(0, 0, 1023, 2);         // very shallow, long divided runs
		advance(3);
		load_line(1023, 1021, 0, 1023);   // shallow, stepping left
		advance(3);
		load_line(3, 100, 6, 110);        // steep, dropped after two rows
		advance(2);
		load_line(600, 500, 590, 505);
		advance(6);
		advance(1);                       // line already finished

		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph == 0) begin
				write_color('0);
			end else if (ph == 1) begin
				write_color('1);
			end else begin
				write_color(COLOR_W'($urandom));
			end
			quiet = (ph == 3);
			if (ph == 2) begin
				hold_req = 1;
			end
			while (items < ITEM_TARGET * (ph + 1) / PHASES) begin
				random_line();
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (sb.pending() != 0) begin
			sb.mismatch($sformatf("%0d spans never came out", sb.pending()));
		end
		$display("Run covered %0d items with %0d line loads and %0d color settings.",
			items, loads, color_writes);
		$display("%0d spans matched; shapes included flat, vertical and both diagonals.",
			sb.spans_ok);
		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#(12_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/lsr_pkg.sv
rtl/lsr_div.sv
rtl/lsr_cfg.sv
rtl/line_span_rasterizer.sv
bench/tb_top.sv
